@@ hw/rtl/pfp_pkg.sv @@
// Package for the parameter frame parser: name table, codes, FSM states and
// the command/status structs between controller and datapath.
// No dependencies.
package pfp_pkg;

    localparam int DEF_MAX_NAME_BYTES = 16;
    localparam int DEF_MAX_WORDS      = 16;
    localparam int NAME_COUNT         = 5;
    localparam int TABLE_ENTRIES      = 5;
    localparam int SEARCH_ENTRIES     = (NAME_COUNT < TABLE_ENTRIES) ? NAME_COUNT
                                                                     : TABLE_ENTRIES;
    localparam int NAME_MAX_LEN       = 10;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 3;
    localparam int ERR_W   = 3;

    // Names right-aligned in 80 bits, first character at the top.
    // Entry 0 is written as its character codes.
    localparam logic [8*NAME_MAX_LEN-1:0] NAME_STR [TABLE_ENTRIES] =
        '{80'h4C4F_4144_5F53_5441_5254, "OneParam", "PID", "CascadePID", "TrackBar"};
    localparam int NAME_LEN [TABLE_ENTRIES] = '{10, 8, 3, 10, 8};

    localparam logic [KIND_W-1:0] KIND_PARAM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ID   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_TAIL = 3'd4;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_ID    = 2'd1;
    localparam logic [1:0] REG_TAIL  = 2'd2;

    localparam logic [7:0] RST_START = 8'd165;
    localparam logic [7:0] RST_ID    = 8'd1;
    localparam logic [7:0] RST_TAIL  = 8'd90;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] param_id_byte;
        logic [7:0] tail_byte;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_ID,
        ST_NLEN,
        ST_WCNT,
        ST_NAME,
        ST_DATA,
        ST_TAIL,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OUT_ERR,
        OUT_FINISH,
        OUT_WORD
    } out_sel_t;

    typedef struct packed {
        logic             ld_nlen;
        logic             ld_wcnt;
        logic             name_step;
        logic             data_step;
        logic             wave_update;
        logic             emit_start;
        logic             emit_step;
        logic             out_load;
        out_sel_t         out_sel;
        logic [ERR_W-1:0] err_code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_hit;
        logic id_ok;
        logic too_long;
        logic rx_zero;
        logic nlen_zero;
        logic name_done;
        logic data_done;
        logic words_zero;
        logic tail_ok;
        logic found;
        logic emit_last;
        logic out_free;
    } dp_stat_t;

    // Character at position pos of table entry e, zero past its end.
    function automatic logic [7:0] name_char(input int e, input int pos);
        logic [7:0] ch;
        ch = 8'd0;
        if (pos < NAME_LEN[e])
        begin
            ch = NAME_STR[e][8*(NAME_LEN[e]-1-pos) +: 8];
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/pfp_rx_if.sv @@
// Byte input channel of the parameter frame parser.
// No dependencies.
interface pfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/pfp_res_if.sv @@
// Result channel of the parameter frame parser.
// Depends on pfp_pkg.
interface pfp_res_if #(
    parameter int COUNT_W = $clog2(pfp_pkg::DEF_MAX_WORDS + 1)
);
    import pfp_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] entry_index;
    logic [31:0]        word_value;
    logic [COUNT_W-1:0] word_count;
    logic [INDEX_W-1:0] wave_select;
    logic [ERR_W-1:0]   error_code;
    logic               last;

    modport source (output valid, output kind, output entry_index, output word_value,
                    output word_count, output wave_select, output error_code,
                    output last, input ready);
    modport sink (input valid, input kind, input entry_index, input word_value,
                  input word_count, input wave_select, input error_code,
                  input last, output ready);
endinterface

@@ hw/rtl/param_frame_parser.sv @@
// Parameter frame parser top level: APB config, controller, datapath.
// Depends on pfp_pkg, pfp_rx_if, pfp_res_if, pfp_cfg_regs, pfp_ctrl, pfp_datapath.
//
// Usage: received bytes arrive one per transfer on rx (valid/ready). A frame is
// start, id, name length, word count, name bytes, 4*count data bytes, tail.
// Results leave on result (valid/ready), each frame ending with one marked last:
// a parameter word per data word, a finish or wave change if none, or an error.
// Output: an error or a frame without words is loaded into the output register
// at the edge that takes its closing byte. The first word of a burst is loaded
// in ST_EMIT after ST_READ, and each later word passes ST_READ and ST_EMIT (one
// registered read port on the word buffer); no input is taken during the drain.
// Throughput: one byte per cycle outside the word drain; an id, count or
// tail byte waits until the output register is free.
// Stall: a stalled receiver holds the result register; bytes that cannot make a
// result keep flowing.
// Reset: rst_n clears the controller to hunting, drops any pending result, turns
// the wave display off and restores the register defaults (start 165, id 1,
// tail 90). The word buffer needs no clearing: each word is written before read.
// Registers: start byte at 0x0, id byte at 0x4, tail byte at 0x8.
module param_frame_parser #(
    parameter int MAX_NAME_BYTES = pfp_pkg::DEF_MAX_NAME_BYTES,
    parameter int MAX_WORDS      = pfp_pkg::DEF_MAX_WORDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    pfp_rx_if.sink                      rx,
    pfp_res_if.source                   result
);
    import pfp_pkg::*;

    localparam int COUNT_W = $clog2(MAX_WORDS + 1);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      rx_ready;

    assign rx.ready = rx_ready;

    pfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfp_datapath #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES),
        .MAX_WORDS      (MAX_WORDS),
        .COUNT_W        (COUNT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .rx_byte     (rx.rx_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .kind        (result.kind),
        .entry_index (result.entry_index),
        .word_value  (result.word_value),
        .word_count  (result.word_count),
        .wave_select (result.wave_select),
        .error_code  (result.error_code),
        .last        (result.last)
    );

endmodule

@@ hw/rtl/pfp_cfg_regs.sv @@
// APB configuration registers: start byte, id byte, tail byte.
// Depends on pfp_pkg.
module pfp_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [pfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output pfp_pkg::cfg_t          cfg
);
    import pfp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= RST_START;
            cfg_reg.param_id_byte <= RST_ID;
            cfg_reg.tail_byte     <= RST_TAIL;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START: cfg_reg.start_byte    <= pwdata[7:0];
                REG_ID:    cfg_reg.param_id_byte <= pwdata[7:0];
                REG_TAIL:  cfg_reg.tail_byte     <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START: prdata = {24'd0, cfg_reg.start_byte};
            REG_ID:    prdata = {24'd0, cfg_reg.param_id_byte};
            REG_TAIL:  prdata = {24'd0, cfg_reg.tail_byte};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/pfp_ctrl.sv @@
// Frame controller: walks the frame layout and issues datapath commands.
// Depends on pfp_pkg.
module pfp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pfp_pkg::dp_stat_t     stat,
    output pfp_pkg::ctrl_cmd_t    cmd
);
    import pfp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel  = OUT_ERR;
        cmd.err_code = ERR_NONE;

        // bytes that can end a frame wait until the result register is free
        case (state_reg)
            ST_HUNT, ST_NLEN, ST_NAME, ST_DATA: in_ready = 1'b1;
            ST_ID, ST_WCNT, ST_TAIL:            in_ready = stat.out_free;
            default:                            in_ready = 1'b0;
        endcase
        acc = in_valid && in_ready;

        case (state_reg)
            ST_HUNT:
            begin
                if (acc && stat.start_hit)
                begin
                    state_next = ST_ID;
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    if (!stat.id_ok)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.err_code = ERR_BAD_ID;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        state_next = ST_NLEN;
                    end
                end
            end
            ST_NLEN:
            begin
                if (acc)
                begin
                    cmd.ld_nlen = 1'b1;
                    state_next  = ST_WCNT;
                end
            end
            ST_WCNT:
            begin
                if (acc)
                begin
                    if (stat.too_long)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.err_code = ERR_TOO_LONG;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.ld_wcnt = 1'b1;
                        if (!stat.nlen_zero)
                            state_next = ST_NAME;
                        else if (stat.rx_zero)
                            state_next = ST_TAIL;
                        else
                            state_next = ST_DATA;
                    end
                end
            end
            ST_NAME:
            begin
                if (acc)
                begin
                    cmd.name_step = 1'b1;
                    if (stat.name_done)
                        state_next = stat.words_zero ? ST_TAIL : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (acc)
                begin
                    cmd.data_step = 1'b1;
                    if (stat.data_done)
                        state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (acc)
                begin
                    if (!stat.tail_ok)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.err_code = ERR_BAD_TAIL;
                        state_next   = ST_HUNT;
                    end
                    else if (!stat.found)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.err_code = ERR_UNKNOWN;
                        state_next   = ST_HUNT;
                    end
                    else
                    begin
                        cmd.wave_update = 1'b1;
                        if (stat.words_zero)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_FINISH;
                            state_next   = ST_HUNT;
                        end
                        else
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_WORD;
                    if (stat.emit_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.emit_step = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

@@ hw/rtl/pfp_datapath.sv @@
// Frame datapath: field registers, name matcher, word buffer, wave selection
// and the result register. Depends on pfp_pkg.
module pfp_datapath #(
    parameter int MAX_NAME_BYTES = pfp_pkg::DEF_MAX_NAME_BYTES,
    parameter int MAX_WORDS      = pfp_pkg::DEF_MAX_WORDS,
    parameter int COUNT_W        = $clog2(MAX_WORDS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfp_pkg::cfg_t                 cfg,
    input  logic [7:0]                    rx_byte,
    input  pfp_pkg::ctrl_cmd_t            cmd,
    output pfp_pkg::dp_stat_t             stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [pfp_pkg::KIND_W-1:0]    kind,
    output logic [pfp_pkg::INDEX_W-1:0]   entry_index,
    output logic [31:0]                   word_value,
    output logic [COUNT_W-1:0]            word_count,
    output logic [pfp_pkg::INDEX_W-1:0]   wave_select,
    output logic [pfp_pkg::ERR_W-1:0]     error_code,
    output logic                          last
);
    import pfp_pkg::*;

    localparam int SPAN   = (MAX_NAME_BYTES > 4*MAX_WORDS) ? MAX_NAME_BYTES : 4*MAX_WORDS;
    localparam int CNT_W  = $clog2(SPAN + 1);
    localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CMP_W  = CNT_W + 2;

    logic [7:0]               nlen_reg;
    logic [COUNT_W-1:0]       words_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [TABLE_ENTRIES-1:0] flags_reg;
    logic [TABLE_ENTRIES-1:0] flags_next;
    logic [23:0]              asm_reg;
    logic [AW-1:0]            idx_reg;
    logic [INDEX_W-1:0]       hit_reg;
    logic [INDEX_W-1:0]       wave_reg;
    logic [INDEX_W-1:0]       wave_next;
    logic [31:0]              rd_data_reg;
    logic [31:0]              buf_mem [MAX_WORDS];

    logic                     out_valid_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic [INDEX_W-1:0]       index_reg;
    logic [31:0]              value_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [INDEX_W-1:0]       wsel_reg;
    logic [ERR_W-1:0]         err_reg;
    logic                     last_reg;

    logic [CMP_W-1:0]         cnt_inc;
    logic [AW-1:0]            waddr;
    logic [1:0]               lane;
    logic                     found;
    logic [INDEX_W-1:0]       hit;

    assign cnt_inc = CMP_W'(cnt_reg) + CMP_W'(1);
    assign waddr   = cnt_reg[2 +: AW];
    assign lane    = cnt_reg[1:0];

    // name matcher: drop entries whose text differs at or ends before this position
    always_comb
    begin
        flags_next = flags_reg;
        for (int e = 0; e < TABLE_ENTRIES; e++)
        begin
            if (int'(cnt_reg) >= NAME_LEN[e] || name_char(e, int'(cnt_reg)) != rx_byte)
                flags_next[e] = 1'b0;
        end
    end

    // lowest matching entry of full length wins
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int e = 0; e < SEARCH_ENTRIES; e++)
        begin
            if (!found && flags_reg[e] && nlen_reg != 8'd0 && nlen_reg == 8'(NAME_LEN[e]))
            begin
                found = 1'b1;
                hit   = INDEX_W'(e);
            end
        end
    end

    always_comb
    begin
        wave_next = wave_reg;
        if (words_reg == '0 && hit != '0)
            wave_next = (wave_reg == hit) ? INDEX_W'(0) : hit;
        else if (hit == '0)
            wave_next = '0;
    end

    always_comb
    begin
        stat.start_hit  = rx_byte == cfg.start_byte;
        stat.id_ok      = rx_byte == cfg.param_id_byte;
        stat.too_long   = nlen_reg > 8'(MAX_NAME_BYTES) || rx_byte > 8'(MAX_WORDS);
        stat.rx_zero    = rx_byte == 8'd0;
        stat.nlen_zero  = nlen_reg == 8'd0;
        stat.name_done  = cnt_inc >= CMP_W'(nlen_reg);
        stat.data_done  = cnt_inc >= CMP_W'({words_reg, 2'b00});
        stat.words_zero = words_reg == '0;
        stat.tail_ok    = rx_byte == cfg.tail_byte;
        stat.found      = found;
        stat.emit_last  = (CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'(words_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_nlen)
            nlen_reg <= rx_byte;
        if (cmd.ld_wcnt)
        begin
            words_reg <= COUNT_W'(rx_byte);
            cnt_reg   <= '0;
            flags_reg <= '1;
        end
        else if (cmd.name_step)
        begin
            flags_reg <= flags_next;
            cnt_reg   <= stat.name_done ? CNT_W'(0) : CNT_W'(cnt_inc);
        end
        else if (cmd.data_step)
        begin
            cnt_reg <= stat.data_done ? CNT_W'(0) : CNT_W'(cnt_inc);
        end
        if (cmd.data_step)
        begin
            case (lane)
                2'd0:    asm_reg[7:0]   <= rx_byte;
                2'd1:    asm_reg[15:8]  <= rx_byte;
                2'd2:    asm_reg[23:16] <= rx_byte;
                default: ;
            endcase
        end
        if (cmd.wave_update)
            hit_reg <= hit;
        if (cmd.emit_start)
            idx_reg <= '0;
        else if (cmd.emit_step)
            idx_reg <= idx_reg + AW'(1);
    end

    // word buffer, written once all four bytes of a word are in
    always_ff @(posedge clk)
    begin
        if (cmd.data_step && lane == 2'd3)
            buf_mem[waddr] <= {rx_byte, asm_reg};
        rd_data_reg <= buf_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wave_update)
                wave_reg <= wave_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_FINISH:
                begin
                    kind_reg  <= (hit == '0) ? KIND_PARAM : KIND_WAVE;
                    index_reg <= hit;
                    value_reg <= '0;
                    count_reg <= '0;
                    wsel_reg  <= wave_next;
                    err_reg   <= ERR_NONE;
                    last_reg  <= 1'b1;
                end
                OUT_WORD:
                begin
                    kind_reg  <= KIND_PARAM;
                    index_reg <= hit_reg;
                    value_reg <= rd_data_reg;
                    count_reg <= words_reg;
                    wsel_reg  <= wave_reg;
                    err_reg   <= ERR_NONE;
                    last_reg  <= stat.emit_last;
                end
                default:
                begin
                    kind_reg  <= KIND_ERROR;
                    index_reg <= '0;
                    value_reg <= '0;
                    count_reg <= '0;
                    wsel_reg  <= wave_reg;
                    err_reg   <= cmd.err_code;
                    last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign entry_index = index_reg;
    assign word_value  = value_reg;
    assign word_count  = count_reg;
    assign wave_select = wsel_reg;
    assign error_code  = err_reg;
    assign last        = last_reg;

endmodule
